// ===== rtl/chacha20_seeded_stream_cipher_top_assert.svh =====
// assertion macros for the seeded chacha20 stream cipher
`ifndef CHACHA20_SEEDED_STREAM_CIPHER_TOP_ASSERT_SVH
`define CHACHA20_SEEDED_STREAM_CIPHER_TOP_ASSERT_SVH
`ifndef SYNTH
`define CCS_ASSERT_IMPL(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`define CCS_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define CCS_ASSERT_IMPL(label, clk, rstn, cond, msg)
`define CCS_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

// ===== rtl/ccs_pkg.sv =====
// shared types, constants and round functions for the seeded chacha20 cipher
package ccs_pkg;
    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int BYTES_PER_ITEM_DEF = 8;
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646E;
    localparam logic [31:0] SIGMA2 = 32'h79622D32;
    localparam logic [31:0] SIGMA3 = 32'h6B206574;
    localparam logic [31:0] SEED_MIX = 32'h60616263;
    localparam logic [31:0] KEY_DELTA [8] = '{32'h00000000, 32'h0A0A0A0A, 32'h0C0C0C0C,
        32'h06060606, 32'h0E0E0E0E, 32'h0A0A0A0A, 32'h06060606, 32'h02020202};

    typedef logic [31:0] word_t;
    typedef word_t [15:0] blk_t;
    typedef logic [127:0] quad_t;

    typedef struct packed {
        logic        start;
        logic [31:0] seed;
        logic [63:0] counter;
    } blk_req_t;

    function automatic word_t rotl(word_t v, int r);
        rotl = (v << r) | (v >> (32 - r));
    endfunction

    // one quarter round, words packed a,b,c,d from high to low
    function automatic quad_t qround(quad_t q);
        word_t a, b, c, d;
        a = q[127:96]; b = q[95:64]; c = q[63:32]; d = q[31:0];
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        qround = {a, b, c, d};
    endfunction
endpackage

// ===== rtl/ccs_qr_lane.sv =====
// one quarter-round lane with its own registered output
module ccs_qr_lane import ccs_pkg::*; (
    input  logic  aclk,
    input  logic  load,
    input  quad_t q_in,
    output quad_t q_out
);
    quad_t q_reg;
    always_ff @(posedge aclk) begin
        if (load) begin
            q_reg <= qround(q_in);
        end
    end
    assign q_out = q_reg;
endmodule

// ===== rtl/ccs_block_core.sv =====
// keystream block generator: four quarter-round lanes iterated over half rounds
module ccs_block_core import ccs_pkg::*; #(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  blk_req_t req,
    output logic     busy,
    output logic     done,
    output blk_t     ks
);
    localparam int HALVES = 2 * DOUBLE_ROUNDS;
    localparam int CW = $clog2(HALVES + 1);

    blk_t init_reg, init_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    blk_t w_cur, w_new;
    quad_t lane_in [4];
    quad_t lane_out [4];
    logic odd_reg, odd_next;
    logic first_reg, first_next;
    blk_t ks_reg, ks_next;
    logic [63:0] ctr;

    // working state lives in the lane registers; the first pass reads the init words
    always_comb begin
        w_cur = init_reg;
        if (!first_reg) begin
            // lane outputs back into word positions of the last half round
            for (int i = 0; i < 4; i++) begin
                if (!odd_reg) begin
                    w_cur[i]      = lane_out[i][127:96];
                    w_cur[4 + i]  = lane_out[i][95:64];
                    w_cur[8 + i]  = lane_out[i][63:32];
                    w_cur[12 + i] = lane_out[i][31:0];
                end else begin
                    w_cur[i]                  = lane_out[i][127:96];
                    w_cur[4 + ((i + 1) % 4)]  = lane_out[i][95:64];
                    w_cur[8 + ((i + 2) % 4)]  = lane_out[i][63:32];
                    w_cur[12 + ((i + 3) % 4)] = lane_out[i][31:0];
                end
            end
        end
        // odd_reg tells what the lanes hold; next pass is the other kind
        for (int i = 0; i < 4; i++) begin
            if (first_reg || odd_reg) begin
                lane_in[i] = {w_cur[i], w_cur[4 + i], w_cur[8 + i], w_cur[12 + i]};
            end else begin
                lane_in[i] = {w_cur[i], w_cur[4 + ((i + 1) % 4)],
                              w_cur[8 + ((i + 2) % 4)], w_cur[12 + ((i + 3) % 4)]};
            end
        end
        w_new = w_cur;
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            ccs_qr_lane u_lane (
                .aclk  (aclk),
                .load  (busy_reg),
                .q_in  (lane_in[g]),
                .q_out (lane_out[g])
            );
        end
    endgenerate

    always_comb begin
        ctr = {req.seed, req.seed} + req.counter;
        init_next = init_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        odd_next = odd_reg;
        first_next = first_reg;
        ks_next = ks_reg;
        if (req.start && !busy_reg) begin
            init_next[0] = SIGMA0; init_next[1] = SIGMA1;
            init_next[2] = SIGMA2; init_next[3] = SIGMA3;
            for (int i = 0; i < 8; i++) begin
                init_next[4 + i] = req.seed ^ SEED_MIX ^ KEY_DELTA[i];
            end
            init_next[12] = ctr[31:0];
            init_next[13] = ctr[63:32];
            init_next[14] = req.seed;
            init_next[15] = req.seed;
            cnt_next = '0;
            busy_next = 1'b1;
            first_next = 1'b1;
            odd_next = 1'b0;
        end else if (busy_reg) begin
            if (cnt_reg == CW'(HALVES)) begin
                // feed-forward merge of lane results
                for (int i = 0; i < 16; i++) begin
                    ks_next[i] = w_new[i] + init_reg[i];
                end
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
                first_next = 1'b0;
                odd_next = first_reg ? 1'b0 : !odd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            odd_reg <= 1'b0;
            first_reg <= 1'b1;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
            odd_reg <= odd_next;
            first_reg <= first_next;
        end
        init_reg <= init_next;
        ks_reg <= ks_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign ks = ks_reg;
endmodule

// ===== rtl/chacha20_seeded_stream_cipher_top.sv =====
// seeded chacha20 stream cipher: byte position control, keystream core, output register
// an accepted word's result is valid in the next cycle while the block is ready
// a word that needs a new block is held while the core starts, runs the half rounds
// through the four quarter-round lanes and marks the keystream ready
// throughput: one word per cycle unless stalled, 64/BYTES_PER_ITEM words per block
// reset: aresetn synchronous active low; clears seed, counter, position and valid flags
module chacha20_seeded_stream_cipher_top import ccs_pkg::*; #(
    parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_word,
    input  logic [3:0]  s_byte_count,
    input  logic        s_first_of_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_word,
    output logic [3:0]  m_result_count
);
    `include "chacha20_seeded_stream_cipher_top_assert.svh"

    localparam int IB = (BYTES_PER_ITEM_DEF < 1) ? 1 :
                        ((BYTES_PER_ITEM_DEF > 8) ? 8 : BYTES_PER_ITEM_DEF);

    logic [31:0] seed_reg;
    logic [63:0] ctr_reg, ctr_next;
    logic [5:0]  pos_reg, pos_next;
    logic        rdy_reg, rdy_next;
    logic        first_done_reg, first_done_next;
    logic        ov_reg;
    logic [63:0] od_reg, od_next;
    logic [3:0]  oc_reg, oc_next;
    logic        busy, done, req_start;
    blk_t        ks;
    blk_req_t    req;
    logic [63:0] ctr_eff;
    logic [5:0]  pos_eff, bp;
    logic [3:0]  cnt;
    logic        eff_first, rdy_eff;
    logic        need, fire, out_free;
    logic [6:0]  pend;
    integer i;

    assign out_free = !ov_reg || m_ready;
    // a word's first flag counts once: at its block request, or when taken if it has no bytes
    assign eff_first = s_first_of_file && !first_done_reg;
    assign ctr_eff = eff_first ? 64'd0 : ctr_reg;
    assign pos_eff = eff_first ? 6'd0 : pos_reg;
    assign rdy_eff = !eff_first && rdy_reg;
    assign cnt = (s_byte_count > 4'(IB)) ? 4'(IB) : s_byte_count;
    // a new block is needed when the word has bytes and keystream is stale
    assign need = (cnt != 4'd0) && !rdy_eff;
    assign fire = s_valid && out_free && !busy && !done && !need;
    assign s_ready = out_free && !busy && !done && !need;
    assign req_start = s_valid && out_free && !busy && !done && need;

    assign req.start = req_start;
    assign req.seed = seed_reg;
    assign req.counter = ctr_eff;

    ccs_block_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .busy    (busy),
        .done    (done),
        .ks      (ks)
    );

    always_comb begin
        od_next = '0;
        for (i = 0; i < IB; i++) begin
            bp = pos_eff + 6'(i);
            if (4'(i) < cnt) begin
                od_next[8*i +: 8] = s_data_word[8*i +: 8] ^ ks[bp[5:2]][8*bp[1:0] +: 8];
            end
        end
        oc_next = cnt;
        pend = {1'b0, pos_eff} + 7'(IB);
        pos_next = pos_reg;
        ctr_next = ctr_reg;
        rdy_next = rdy_reg;
        first_done_next = first_done_reg;
        if (req_start) begin
            // counter and position take their effective values (zero at a file start) before the block is made
            pos_next = pos_eff;
            ctr_next = ctr_eff;
            rdy_next = 1'b0;
            first_done_next = s_first_of_file;
        end else if (fire) begin
            pos_next = pend[5:0];
            ctr_next = ctr_eff;
            rdy_next = rdy_eff;
            first_done_next = 1'b0;
            if (pend[6]) begin
                ctr_next = ctr_eff + 64'd1;
                rdy_next = 1'b0;
            end
        end
        if (done) begin
            rdy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
            ctr_reg <= '0;
            pos_reg <= '0;
            rdy_reg <= 1'b0;
            first_done_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                seed_reg <= cfg_wdata;
            end
            ctr_reg <= ctr_next;
            pos_reg <= pos_next;
            rdy_reg <= rdy_next;
            first_done_reg <= first_done_next;
            if (fire) begin
                ov_reg <= 1'b1;
            end else if (m_ready) begin
                ov_reg <= 1'b0;
            end
        end
        if (fire) begin
            od_reg <= od_next;
            oc_reg <= oc_next;
        end
    end

    assign m_valid = ov_reg;
    assign m_result_word = od_reg;
    assign m_result_count = oc_reg;

    `CCS_ASSERT_IMPL(a_no_fire_busy, aclk, aresetn, !(fire && busy), "word taken while core busy")
    `CCS_ASSERT_NEXT(a_done_ready, aclk, aresetn, done, rdy_reg, "keystream not marked ready")
    `CCS_ASSERT_IMPL(a_ks_ready, aclk, aresetn, !(fire && cnt != 4'd0) || rdy_reg, "stale keystream used")
endmodule

// ===== sim/tb_chacha20_seeded_stream_cipher_top.sv =====
// testbench for the seeded chacha20 stream cipher: directed and random words checked against a keystream model
`timescale 1ns / 1ps
module tb_chacha20_seeded_stream_cipher_top;
    import ccs_pkg::*;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
        logic        first;
    } in_word_t;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  count;
    } out_word_t;

    localparam int ITEM_BYTES = 8;
    localparam int DRAIN_CYCLES = 2 * DOUBLE_ROUNDS_DEF + 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data_word = '0;
    logic [3:0]  s_byte_count = '0;
    logic        s_first_of_file = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_word;
    logic [3:0]  m_result_count;

    in_word_t  pending_words[$];
    out_word_t expected_words[$];
    int        mismatches = 0;
    bit        send_idle_en = 1'b1;
    bit        recv_idle_en = 1'b1;
    bit        recv_hold_on = 1'b0;

    // cipher state kept alongside the block
    logic [31:0] seed_r = '0;
    logic [63:0] blk_count = '0;
    logic [31:0] ks_words[16];
    int          byte_pos = 0;
    bit          ks_valid = 1'b0;

    chacha20_seeded_stream_cipher_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_word(s_data_word),
        .s_byte_count(s_byte_count), .s_first_of_file(s_first_of_file),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_word(m_result_word),
        .m_result_count(m_result_count)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] rot_left(logic [31:0] v, int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    task automatic mix_quarter(inout logic [31:0] w[16], input int a, int b, int c, int d);
        w[a] = w[a] + w[b]; w[d] = rot_left(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rot_left(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rot_left(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rot_left(w[b] ^ w[c], 7);
    endtask

    task automatic build_keystream();
        logic [31:0] init[16];
        logic [31:0] w[16];
        logic [63:0] ctr;
        ctr = {seed_r, seed_r} + blk_count;
        init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
        for (int i = 0; i < 8; i++) init[4 + i] = seed_r ^ SEED_MIX ^ KEY_DELTA[i];
        init[12] = ctr[31:0];
        init[13] = ctr[63:32];
        init[14] = seed_r;
        init[15] = seed_r;
        w = init;
        for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++) begin
            mix_quarter(w, 0, 4, 8, 12);
            mix_quarter(w, 1, 5, 9, 13);
            mix_quarter(w, 2, 6, 10, 14);
            mix_quarter(w, 3, 7, 11, 15);
            mix_quarter(w, 0, 5, 10, 15);
            mix_quarter(w, 1, 6, 11, 12);
            mix_quarter(w, 2, 7, 8, 13);
            mix_quarter(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) ks_words[i] = w[i] + init[i];
        ks_valid = 1'b1;
    endtask

    task automatic encrypt_word(input in_word_t iw);
        out_word_t ow;
        int        n;
        logic [31:0] kw;
        if (iw.first) begin
            blk_count = '0;
            byte_pos = 0;
            ks_valid = 1'b0;
        end
        n = (iw.count > ITEM_BYTES) ? ITEM_BYTES : int'(iw.count);
        ow.data = '0;
        ow.count = 4'(n);
        for (int i = 0; i < ITEM_BYTES; i++) begin
            if (i < n) begin
                if (!ks_valid) build_keystream();
                kw = ks_words[byte_pos >> 2];
                ow.data[8*i +: 8] = iw.data[8*i +: 8] ^ kw[8*(byte_pos & 3) +: 8];
            end
            byte_pos = (byte_pos + 1) & 63;
            if (byte_pos == 0) begin
                blk_count = blk_count + 1;
                ks_valid = 1'b0;
            end
        end
        expected_words = {expected_words, ow};
    endtask

    function automatic in_word_t rand_word(bit first);
        in_word_t iw;
        int sel;
        iw.data = {$urandom, $urandom};
        iw.first = first;
        sel = $urandom_range(0, 19);
        if (sel == 0) iw.count = 4'd0;
        else if (sel == 1) iw.count = 4'($urandom_range(9, 15));
        else if (sel < 5) iw.count = 4'($urandom_range(1, 7));
        else iw.count = 4'd8;
        return iw;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold the offered word
        end else if (pending_words.size() != 0
                     && !(send_idle_en && $urandom_range(0, 99) < 36)) begin
            in_word_t iw;
            iw = pending_words.pop_front();
            encrypt_word(iw);
            s_valid <= 1'b1;
            s_data_word <= iw.data;
            s_byte_count <= iw.count;
            s_first_of_file <= iw.first;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: data=%h count=%0d", m_result_word,
                             m_result_count);
            end else begin
                out_word_t ow;
                ow = expected_words.pop_front();
                if (ow.data !== m_result_word || ow.count !== m_result_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected data=%h count=%0d, got data=%h count=%0d",
                                 ow.data, ow.count, m_result_word, m_result_count);
                end
            end
        end
        if (recv_hold_on) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(recv_idle_en && $urandom_range(0, 99) < 36);
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_valid || expected_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        seed_r = v;
    endtask

    task automatic queue_file(input int len);
        for (int i = 0; i < len; i++) pending_words = {pending_words, rand_word(i == 0)};
    endtask

    initial begin
        in_word_t iw;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset seed, extremes of data and count, block crossings
        for (int i = 0; i < 20; i++) begin
            iw.first = (i == 0) || (i == 17);
            iw.data = (i % 3 == 0) ? 64'h0 : (i % 3 == 1) ? '1 : {$urandom, $urandom};
            iw.count = (i < 16) ? i[3:0] : 4'd8;
            pending_words = {pending_words, iw};
        end
        wait_drained();

        write_seed(32'hFFFF_FFFF);
        queue_file(20);
        wait_drained();

        // counter carry out of the low word with seed near the top
        write_seed(32'hFFFF_FFFE);
        queue_file(30);
        wait_drained();

        // receiver stall long enough for the input to back up
        fork
            begin
                recv_hold_on = 1'b1;
                repeat (300) @(posedge aclk);
                recv_hold_on = 1'b0;
            end
        join_none
        queue_file(40);
        wait_drained();

        // seed change before a file, then another in mid-file, with the file carried on without a first flag
        write_seed($urandom);
        queue_file(12);
        wait_drained();
        write_seed($urandom);
        for (int i = 0; i < 20; i++) pending_words = {pending_words, rand_word(1'b0)};
        wait_drained();

        // stretch with no idling on either side
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        write_seed(32'h0);
        queue_file(100);
        wait_drained();
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;

        for (int f = 0; f < 40; f++) begin
            if ($urandom_range(0, 3) == 0) write_seed($urandom);
            queue_file($urandom_range(1, 70));
            if ($urandom_range(0, 4) == 0)
                pending_words = {pending_words, rand_word(1'($urandom_range(0, 1)))};
            wait_drained();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
